>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_GRANULES = 1024;
    localparam int GRAN_SHIFT    = 4;                         // 16-byte granules
    localparam int IDX_W         = $clog2(HEAP_GRANULES);     // table index
    localparam int POS_W         = IDX_W + 1;                 // position incl. end
    localparam int WANT_W        = 33 - GRAN_SHIFT;           // rounded request

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_FREED   = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic             starts;
        logic             is_free;
        logic [POS_W-1:0] len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             clr;
        logic             acc;
        logic             is_free;
        logic [POS_W-1:0] len;
    } t_stat_ctl;

    typedef enum logic [3:0] {
        S_INIT, S_CLEAR, S_IDLE, S_A_RD, S_A_SPLIT,
        S_F_RD1, S_F_RD2, S_F_PP, S_F_RD3, S_F_WRG, S_SCAN, S_DONE
    } t_state;

endpackage

>>> rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port synchronous RAM, registered read, write-first.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

>>> rtl/ffha_stats.sv
// ----------------------------------------------------------------------------
// ffha_stats
// Usage totals gathered block by block during the heap walk.
// ----------------------------------------------------------------------------
module ffha_stats (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffha_pkg::t_stat_ctl   i_ctl,
    output logic [14:0]           o_used_bytes,
    output logic [14:0]           o_free_bytes,
    output logic [14:0]           o_largest_free_bytes,
    output logic [9:0]            o_used_block_count,
    output logic [9:0]            o_free_block_count
);
    import ffha_pkg::*;

    logic [POS_W-1:0] r_used_g, r_free_g, r_big_g;
    logic [POS_W-1:0] r_used_n, r_free_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_used_g <= '0;
            r_free_g <= '0;
            r_big_g  <= '0;
            r_used_n <= '0;
            r_free_n <= '0;
        end else if (i_ctl.acc) begin
            if (i_ctl.is_free) begin
                r_free_g <= r_free_g + i_ctl.len;
                r_free_n <= r_free_n + 1'b1;
                if (i_ctl.len > r_big_g) begin
                    r_big_g <= i_ctl.len;
                end
            end else begin
                r_used_g <= r_used_g + i_ctl.len + 1'b1;
                r_used_n <= r_used_n + 1'b1;
            end
        end
    end

    assign o_used_bytes         = 15'({r_used_g, 4'b0});
    assign o_free_bytes         = 15'({r_free_g, 4'b0});
    assign o_largest_free_bytes = 15'({r_big_g, 4'b0});
    assign o_used_block_count   = r_used_n[9:0];
    assign o_free_block_count   = r_free_n[9:0];
endmodule

>>> rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit granule heap allocator with split and two-sided coalescing.
// ----------------------------------------------------------------------------
//  channel  | signals                                            | dir
//  command  | i_start, o_busy, i_command, i_request_bytes,       | in
//           | i_payload_address                                  |
//  result   | o_done, o_granted_address, o_status, o_*_bytes,    | out
//           | o_used_block_count, o_free_block_count             |
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  | in
//
// Allocate: the first-fit walk visits the blocks in S_A_RD, a split adds
// S_A_SPLIT, then S_SCAN walks every block for the statistics and S_DONE
// gives the result. Free: table access in S_F_RD1, S_F_RD2, S_F_PP, S_F_RD3
// and S_F_WRG as needed, then the statistics walk and the result.
// After reset and after every config write a clearing pass in S_CLEAR
// rebuilds the table; o_busy stays high meanwhile.
// o_done lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_payload_address,
    output logic        o_done,
    output logic [31:0] o_granted_address,
    output logic [1:0]  o_status,
    output logic [14:0] o_used_bytes,
    output logic [14:0] o_free_bytes,
    output logic [14:0] o_largest_free_bytes,
    output logic [9:0]  o_used_block_count,
    output logic [9:0]  o_free_block_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ffha_pkg::*;

    t_state r_state, n_state;

    logic [31:0]       r_cfg_start, r_cfg_end;
    logic [WANT_W-1:0] r_base_g, n_base_g;
    logic [POS_W-1:0]  r_hlen, n_hlen;
    logic [POS_W-1:0]  r_b, n_b, r_g, n_g, r_len, n_len, r_nb, n_nb, r_left, n_left;
    logic [IDX_W-1:0]  r_pp, n_pp;
    logic [WANT_W-1:0] r_want, n_want;
    logic [1:0]        r_status, n_status;
    logic [31:0]       r_grant, n_grant;

    // table ports
    logic              a_we, p_we;
    logic [IDX_W-1:0]  a_wa, p_wa, rd_addr;
    t_entry            a_wd, qa;
    logic [IDX_W-1:0]  p_wd, qp;
    logic [ENTRY_W-1:0] qa_raw;
    t_stat_ctl         sctl;

    ffha_ram #(.DEPTH(HEAP_GRANULES), .WIDTH(ENTRY_W)) u_blk (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(rd_addr), .o_rdata(qa_raw)
    );
    assign qa = t_entry'(qa_raw);

    ffha_ram #(.DEPTH(HEAP_GRANULES), .WIDTH(IDX_W)) u_prev (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(rd_addr), .o_rdata(qp)
    );

    ffha_stats u_stats (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sctl),
        .o_used_bytes(o_used_bytes), .o_free_bytes(o_free_bytes),
        .o_largest_free_bytes(o_largest_free_bytes),
        .o_used_block_count(o_used_block_count),
        .o_free_block_count(o_free_block_count)
    );

    // heap geometry from the config registers
    logic [WANT_W-1:0] s_g, n_raw;
    logic [27:0]       e_g;
    logic [POS_W-1:0]  hlen_c;
    always_comb begin
        s_g   = WANT_W'(({1'b0, r_cfg_start} + 33'd15) >> GRAN_SHIFT);
        e_g   = r_cfg_end[31:GRAN_SHIFT];
        n_raw = ({1'b0, e_g} > s_g) ? ({1'b0, e_g} - s_g) : '0;
        if (n_raw > WANT_W'(HEAP_GRANULES)) begin
            hlen_c = POS_W'(HEAP_GRANULES);
        end else if (n_raw < WANT_W'(2)) begin
            hlen_c = '0;
        end else begin
            hlen_c = n_raw[POS_W-1:0];
        end
    end

    // free address decode
    logic [33:0] base34, off34;
    logic [29:0] off_g;
    logic        free_ok;
    always_comb begin
        base34  = {1'b0, r_base_g, 4'b0};
        off34   = {2'b0, i_payload_address} - base34;
        off_g   = off34[33:GRAN_SHIFT] - 30'd1;
        free_ok = (r_hlen != '0) && ({2'b0, i_payload_address} >= base34 + 34'd16) &&
                  (off34[GRAN_SHIFT-1:0] == '0) && (off_g < {19'b0, r_hlen});
    end

    logic [POS_W-1:0] nxt, fit_left, g_next;
    logic             fits;
    logic [32:0]      grant_c;
    always_comb begin
        nxt      = r_b + POS_W'(1) + qa.len;
        fits     = qa.is_free && ({{(WANT_W-POS_W){1'b0}}, qa.len} >= r_want);
        fit_left = qa.len - r_want[POS_W-1:0];
        g_next   = r_g + POS_W'(1) + r_len;
        grant_c  = {r_base_g, 4'b0} + {18'b0, r_b + POS_W'(1), 4'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cfg_start <= 32'd0;
            r_cfg_end   <= 32'd16384;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_state <= S_INIT;
                if (i_cfg_index == CFG_START) begin
                    r_cfg_start <= i_cfg_data;
                end else begin
                    r_cfg_end <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_g <= n_base_g;
        r_hlen   <= n_hlen;
        r_b      <= n_b;
        r_g      <= n_g;
        r_len    <= n_len;
        r_nb     <= n_nb;
        r_left   <= n_left;
        r_pp     <= n_pp;
        r_want   <= n_want;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    always_comb begin
        n_state  = r_state;
        n_base_g = r_base_g;
        n_hlen   = r_hlen;
        n_b      = r_b;
        n_g      = r_g;
        n_len    = r_len;
        n_nb     = r_nb;
        n_left   = r_left;
        n_pp     = r_pp;
        n_want   = r_want;
        n_status = r_status;
        n_grant  = r_grant;
        a_we     = 1'b0;
        a_wa     = r_b[IDX_W-1:0];
        a_wd     = '0;
        p_we     = 1'b0;
        p_wa     = r_b[IDX_W-1:0];
        p_wd     = '0;
        rd_addr  = '0;
        sctl     = '0;
        unique case (r_state)
            S_INIT: begin
                n_base_g = s_g;
                n_hlen   = hlen_c;
                n_b      = '0;
                n_state  = S_CLEAR;
            end
            S_CLEAR: begin
                a_we = 1'b1;
                if (r_b == '0 && r_hlen != '0) begin
                    a_wd = '{starts: 1'b1, is_free: 1'b1, len: r_hlen - POS_W'(1)};
                end
                n_b = r_b + POS_W'(1);
                if (r_b == POS_W'(HEAP_GRANULES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_grant = '0;
                    n_b     = '0;
                    n_want  = WANT_W'(({1'b0, i_request_bytes} + 33'd15) >> GRAN_SHIFT);
                    if (i_command == CMD_ALLOC) begin
                        n_status = ST_NOFIT;
                        if (i_request_bytes == '0 || r_hlen == '0) begin
                            sctl.clr = 1'b1;
                            n_state  = (r_hlen == '0) ? S_DONE : S_SCAN;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        n_status = ST_IGNORED;
                        n_g      = off_g[POS_W-1:0];
                        if (free_ok) begin
                            rd_addr = off_g[IDX_W-1:0];
                            n_state = S_F_RD1;
                        end else begin
                            sctl.clr = 1'b1;
                            n_state  = (r_hlen == '0) ? S_DONE : S_SCAN;
                        end
                    end
                end
            end
            S_A_RD: begin
                if (fits) begin
                    a_we     = 1'b1;
                    a_wd     = '{starts: 1'b1, is_free: 1'b0,
                                 len: (fit_left >= POS_W'(2)) ? r_want[POS_W-1:0] : qa.len};
                    n_status = ST_ALLOC;
                    n_grant  = grant_c[31:0];
                    n_nb     = r_b + POS_W'(1) + r_want[POS_W-1:0];
                    n_left   = fit_left;
                    if (fit_left >= POS_W'(2)) begin
                        p_we    = (nxt < r_hlen);
                        p_wa    = nxt[IDX_W-1:0];
                        p_wd    = n_nb[IDX_W-1:0];
                        n_state = S_A_SPLIT;
                    end else begin
                        sctl.clr = 1'b1;
                        n_b      = '0;
                        n_state  = S_SCAN;
                    end
                end else if (nxt < r_hlen) begin
                    rd_addr = nxt[IDX_W-1:0];
                    n_b     = nxt;
                end else begin
                    sctl.clr = 1'b1;
                    n_b      = '0;
                    n_state  = S_SCAN;
                end
            end
            S_A_SPLIT: begin
                a_we     = 1'b1;
                a_wa     = r_nb[IDX_W-1:0];
                a_wd     = '{starts: 1'b1, is_free: 1'b1, len: r_left - POS_W'(1)};
                p_we     = 1'b1;
                p_wa     = r_nb[IDX_W-1:0];
                p_wd     = r_b[IDX_W-1:0];
                sctl.clr = 1'b1;
                n_b      = '0;
                n_state  = S_SCAN;
            end
            S_F_RD1: begin
                if (!qa.starts || qa.is_free) begin
                    sctl.clr = 1'b1;
                    n_b      = '0;
                    n_state  = S_SCAN;
                end else begin
                    n_status = ST_FREED;
                    n_len    = qa.len;
                    n_pp     = qp;
                    n_b      = r_g + POS_W'(1) + qa.len;
                    if (n_b < r_hlen) begin
                        rd_addr = n_b[IDX_W-1:0];
                        n_state = S_F_RD2;
                    end else begin
                        n_state = S_F_PP;
                    end
                end
            end
            S_F_RD2: begin
                if (qa.is_free) begin
                    n_len = r_len + POS_W'(1) + qa.len;
                    a_we  = 1'b1;
                    a_wd  = '{starts: 1'b0, is_free: 1'b1, len: qa.len};
                end
                n_state = S_F_PP;
            end
            S_F_PP: begin
                if (r_g != '0) begin
                    rd_addr = r_pp;
                    n_state = S_F_RD3;
                end else begin
                    a_we     = 1'b1;
                    a_wa     = r_g[IDX_W-1:0];
                    a_wd     = '{starts: 1'b1, is_free: 1'b1, len: r_len};
                    p_we     = (g_next < r_hlen);
                    p_wa     = g_next[IDX_W-1:0];
                    p_wd     = r_g[IDX_W-1:0];
                    sctl.clr = 1'b1;
                    n_b      = '0;
                    n_state  = S_SCAN;
                end
            end
            S_F_RD3: begin
                a_we = 1'b1;
                p_we = (g_next < r_hlen);
                p_wa = g_next[IDX_W-1:0];
                if (qa.is_free) begin
                    a_wa    = r_pp;
                    a_wd    = '{starts: 1'b1, is_free: 1'b1,
                                len: qa.len + POS_W'(1) + r_len};
                    p_wd    = r_pp;
                    n_state = S_F_WRG;
                end else begin
                    a_wa     = r_g[IDX_W-1:0];
                    a_wd     = '{starts: 1'b1, is_free: 1'b1, len: r_len};
                    p_wd     = r_g[IDX_W-1:0];
                    sctl.clr = 1'b1;
                    n_b      = '0;
                    n_state  = S_SCAN;
                end
            end
            S_F_WRG: begin
                a_we     = 1'b1;
                a_wa     = r_g[IDX_W-1:0];
                a_wd     = '{starts: 1'b0, is_free: 1'b1, len: r_len};
                sctl.clr = 1'b1;
                n_b      = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                sctl.acc     = 1'b1;
                sctl.is_free = qa.is_free;
                sctl.len     = qa.len;
                if (nxt < r_hlen) begin
                    rd_addr = nxt[IDX_W-1:0];
                    n_b     = nxt;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = (r_state == S_DONE);
    assign o_cfg_ready       = 1'b1;
    assign o_granted_address = r_grant;
    assign o_status          = r_status;
endmodule

>>> rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [31:0] o_granted_address,
    input logic [1:0]  o_status
);
    import ffha_pkg::*;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("item taken but not busy");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result outside of item");

    a_grant_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_status == ST_ALLOC) == (o_granted_address != 32'd0)))
        else $error("granted address does not match status");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_granted_address(o_granted_address), .o_status(o_status)
);
